/* hw/rtl/tgs_pkg.sv */
// Shared types, constants and codes of the trilinear grid sampler.
package tgs_pkg;

   // Default values of the top-level parameters.
   localparam int MAX_DIM_DEF   = 32;
   localparam int FRAC_BITS_DEF = 16;

   // Grid geometry: node counts per axis are six-bit fields.
   localparam int DIM_W     = 6;
   localparam int CNT_W     = 3 * DIM_W;
   localparam int MEM_DEPTH = 32768;
   localparam int ADDR_W    = 15;
   localparam int NCORNERS  = 8;

   // Request kinds.
   typedef enum logic {
      KIND_WRITE  = 1'b0,
      KIND_SAMPLE = 1'b1
   } kind_type;

   // Response status codes.
   typedef enum logic [2:0] {
      ST_SAMPLED     = 3'd0,
      ST_OUTSIDE     = 3'd1,
      ST_BAD_CFG     = 3'd2,
      ST_WRITE_DONE  = 3'd3,
      ST_WRITE_RANGE = 3'd4
   } status_type;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      REG_ORIGIN_X  = 3'd0,
      REG_ORIGIN_Y  = 3'd1,
      REG_ORIGIN_Z  = 3'd2,
      REG_INV_X     = 3'd3,
      REG_INV_Y     = 3'd4,
      REG_INV_Z     = 3'd5,
      REG_GRID_DIMS = 3'd6
   } csr_index_type;

   // Request payload.
   typedef struct packed {
      kind_type            kind;
      logic [ADDR_W-1:0]   node_index;
      logic signed [31:0]  write_value;
      logic signed [31:0]  point_x;
      logic signed [31:0]  point_y;
      logic signed [31:0]  point_z;
   } req_payload_type;

   // Response payload.
   typedef struct packed {
      logic signed [31:0]  sample_value;
      status_type          status;
   } rsp_payload_type;

   // Per-axis mapping result.
   typedef struct packed {
      logic              outside;
      logic [DIM_W-1:0]  cell_idx;
   } axis_res_type;

   // Control word carried down the pipeline with each request.
   typedef struct packed {
      kind_type    kind;
      status_type  status;
   } ctl_type;

endpackage

/* hw/rtl/tgs_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module tgs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds while the read is not enabled.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/tgs_axis.sv */
// Three-stage mapping of one coordinate axis to a grid cell and a fraction.
module tgs_axis import tgs_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [31:0]       point,
   input  logic signed [31:0]       origin,
   input  logic [31:0]              inv_spacing,
   input  logic [DIM_W-1:0]         dim,
   output axis_res_type             res,
   output logic [FRAC_BITS:0]       frac
);

   localparam int FW = FRAC_BITS + 1;
   localparam int IW = 64 - 2 * FRAC_BITS;

   logic signed [32:0]  diff_in, diff_ff;
   logic                neg_ff;
   logic [63:0]         mag_in, mag_ff;
   logic [IW-1:0]       hi;
   logic [IW-1:0]       dim_m1;
   logic [IW-1:0]       dim_m2;
   logic                lo_zero;
   logic                clamp;
   axis_res_type        res_in, res_ff;
   logic [FW-1:0]       frac_in, frac_ff;

   // Stage one: offset from the origin.
   assign diff_in = 33'(point) - 33'(origin);

   // Stage two: scale to node space; a negative offset is outside.
   assign mag_in = 64'(diff_ff[31:0]) * 64'(inv_spacing);

   // Stage three: range check, cell index with clamp, and fraction.
   always_comb begin
      hi      = mag_ff[63:2*FRAC_BITS];
      lo_zero = (mag_ff[2*FRAC_BITS-1:0] == '0);
      dim_m1  = IW'(dim) - IW'(1);
      dim_m2  = IW'(dim) - IW'(2);
      clamp   = (hi > dim_m2);
      res_in.outside = neg_ff || (hi > dim_m1) || ((hi == dim_m1) && !lo_zero);
      if (clamp) begin
         res_in.cell_idx = DIM_W'(dim_m2);
         frac_in         = FW'(1) << FRAC_BITS;
      end else begin
         res_in.cell_idx = DIM_W'(hi);
         frac_in         = {1'b0, mag_ff[2*FRAC_BITS-1:FRAC_BITS]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff <= diff_in;
         neg_ff  <= diff_ff[32];
         mag_ff  <= mag_in;
         res_ff  <= res_in;
         frac_ff <= frac_in;
      end
   end

   assign res  = res_ff;
   assign frac = frac_ff;

endmodule

/* hw/rtl/tgs_lerp.sv */
// Two-stage linear interpolation with round-to-nearest, ties toward plus infinity.
module tgs_lerp import tgs_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [31:0]    a,
   input  logic signed [31:0]    b,
   input  logic [FRAC_BITS:0]    f,
   output logic signed [31:0]    y
);

   localparam int PW = 35 + FRAC_BITS;
   localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

   logic signed [32:0]         diff;
   logic signed [FRAC_BITS+1:0] fs;
   logic signed [PW-1:0]       prod_in, prod_ff;
   logic signed [31:0]         a_ff;
   logic signed [PW-1:0]       shifted;
   logic signed [33:0]         sum;
   logic signed [31:0]         y_ff;

   // Stage one: weighted difference.
   always_comb begin
      diff    = 33'(b) - 33'(a);
      fs      = $signed({1'b0, f});
      prod_in = diff * fs;
   end

   // Stage two: round, scale down and add the base value.
   always_comb begin
      shifted = (prod_ff + HALF) >>> FRAC_BITS;
      sum     = 34'(a_ff) + shifted[33:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         a_ff    <= a;
         y_ff    <= sum[31:0];
      end
   end

   assign y = y_ff;

endmodule

/* hw/rtl/trilinear_grid_sampler_unit.sv */
// Top level of the trilinear grid sampler: pipeline control, grid memory and datapath.
//
// The request channel (req_valid, req_stall, req_data) carries either a grid write or a
// sample point; each request produces exactly one response on the rsp_ channel, in
// request order. A write stores write_value at node_index and answers with a write
// status. A sample maps the point to node space, rejects it when outside the grid or
// on bad settings, else interpolates the eight surrounding nodes in x, then y, then z.
// The csr_ channel writes the origin, inverse spacing and node-count registers; it is
// always ready and must only be used while no request is in flight.
// One request can be accepted every cycle unless a held response stalls the pipeline;
// the rate is set by the eight replicated grid memories, which serve the eight corner
// reads of a sample together.
// A synchronous reset empties the pipeline and restores the register defaults; the
// grid memory is not cleared, and a node must be written before it is sampled.
// When the receiver stalls a valid response, the whole pipeline holds and req_stall
// rises in the same cycle; nothing is lost or repeated.
module trilinear_grid_sampler_unit import tgs_pkg::*; #(
   parameter int MAX_DIM   = MAX_DIM_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_payload_type  req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_payload_type  rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  csr_index_type    csr_index,
   input  logic [31:0]      csr_wdata
);

   localparam int FW     = FRAC_BITS + 1;
   localparam int NSTAGE = 12;
   localparam int BW     = CNT_W + 1;

   // Configuration registers and values derived from them.
   logic signed [31:0]  origin_x_ff, origin_y_ff, origin_z_ff;
   logic [31:0]         inv_x_ff, inv_y_ff, inv_z_ff;
   logic [CNT_W-1:0]    grid_dims_ff;
   logic [DIM_W-1:0]    nx, ny, nz;
   logic [2*DIM_W-1:0]  nxy_in, nxy_ff;
   logic [CNT_W-1:0]    count_in, count_ff;
   logic                cfg_bad_in, cfg_bad_ff;

   // Pipeline control.
   logic                en;
   logic                vld_ff [1:NSTAGE];
   ctl_type             ctl_in [2:NSTAGE];
   ctl_type             ctl_ff [2:NSTAGE];
   req_payload_type     req_ff;
   logic [ADDR_W-1:0]   widx_ff [2:5];
   logic signed [31:0]  wval_ff [2:5];

   // Axis mapping results.
   axis_res_type        res_x, res_y, res_z;
   logic [FW-1:0]       frac_x, frac_y, frac_z;
   logic [FW-1:0]       fx_ff [5:6];
   logic [FW-1:0]       fy_ff [5:8];
   logic [FW-1:0]       fz_ff [5:10];

   // Corner addresses, memory data and interpolation results.
   logic [BW-1:0]       base;
   logic [BW-1:0]       off [NCORNERS];
   logic [ADDR_W-1:0]   addr_in [NCORNERS];
   logic [ADDR_W-1:0]   addr_ff [NCORNERS];
   logic [31:0]         node [NCORNERS];
   logic                mem_wr;
   logic signed [31:0]  c00, c10, c01, c11, c0, c1, v;

   // Output register.
   logic                rsp_valid_ff;
   rsp_payload_type     rsp_data_ff;

   // Configuration register writes.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         origin_z_ff  <= '0;
         inv_x_ff     <= 32'd65536;
         inv_y_ff     <= 32'd65536;
         inv_z_ff     <= 32'd65536;
         grid_dims_ff <= CNT_W'(8322);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_ORIGIN_X:  origin_x_ff  <= csr_wdata;
            REG_ORIGIN_Y:  origin_y_ff  <= csr_wdata;
            REG_ORIGIN_Z:  origin_z_ff  <= csr_wdata;
            REG_INV_X:     inv_x_ff     <= csr_wdata;
            REG_INV_Y:     inv_y_ff     <= csr_wdata;
            REG_INV_Z:     inv_z_ff     <= csr_wdata;
            REG_GRID_DIMS: grid_dims_ff <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Node counts, strides and the validity of the grid settings.
   always_comb begin
      nx         = grid_dims_ff[DIM_W-1:0];
      ny         = grid_dims_ff[2*DIM_W-1:DIM_W];
      nz         = grid_dims_ff[3*DIM_W-1:2*DIM_W];
      nxy_in     = (2*DIM_W)'(nx) * (2*DIM_W)'(ny);
      count_in   = CNT_W'(nxy_in) * CNT_W'(nz);
      cfg_bad_in = (nx < DIM_W'(2)) || (ny < DIM_W'(2)) || (nz < DIM_W'(2)) ||
                   (nx > DIM_W'(MAX_DIM)) || (ny > DIM_W'(MAX_DIM)) ||
                   (nz > DIM_W'(MAX_DIM)) || (count_in > CNT_W'(MEM_DEPTH)) ||
                   (inv_x_ff == '0) || (inv_y_ff == '0) || (inv_z_ff == '0);
   end

   always_ff @(posedge clock) begin
      nxy_ff     <= nxy_in;
      count_ff   <= count_in;
      cfg_bad_ff <= cfg_bad_in;
   end

   // The pipeline advances unless a finished response is held by the receiver.
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // Status and control word of each stage.
   always_comb begin
      ctl_in[2].kind = req_ff.kind;
      if (req_ff.kind == KIND_WRITE) begin
         ctl_in[2].status = ({3'b000, req_ff.node_index} < count_ff) ? ST_WRITE_DONE
                                                                     : ST_WRITE_RANGE;
      end else begin
         ctl_in[2].status = cfg_bad_ff ? ST_BAD_CFG : ST_SAMPLED;
      end
      for (int s = 3; s <= NSTAGE; s++) begin
         ctl_in[s] = ctl_ff[s-1];
      end
      if ((ctl_ff[4].kind == KIND_SAMPLE) && (ctl_ff[4].status == ST_SAMPLED) &&
          (res_x.outside || res_y.outside || res_z.outside)) begin
         ctl_in[5].status = ST_OUTSIDE;
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 1; s <= NSTAGE; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[1] <= req_valid;
         for (int s = 2; s <= NSTAGE; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   // Payload stages.
   always_ff @(posedge clock) begin
      if (en) begin
         req_ff     <= req_data;
         widx_ff[2] <= req_ff.node_index;
         wval_ff[2] <= req_ff.write_value;
         for (int s = 3; s <= 5; s++) begin
            widx_ff[s] <= widx_ff[s-1];
            wval_ff[s] <= wval_ff[s-1];
         end
         for (int s = 2; s <= NSTAGE; s++) begin
            ctl_ff[s] <= ctl_in[s];
         end
         fx_ff[5] <= frac_x;
         fy_ff[5] <= frac_y;
         fz_ff[5] <= frac_z;
         fx_ff[6] <= fx_ff[5];
         for (int s = 6; s <= 8; s++) begin
            fy_ff[s] <= fy_ff[s-1];
         end
         for (int s = 6; s <= 10; s++) begin
            fz_ff[s] <= fz_ff[s-1];
         end
         for (int g = 0; g < NCORNERS; g++) begin
            addr_ff[g] <= addr_in[g];
         end
      end
   end

   // Map each axis to a cell and a fraction.
   tgs_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
      .clock(clock), .en(en), .point(req_ff.point_x), .origin(origin_x_ff),
      .inv_spacing(inv_x_ff), .dim(nx), .res(res_x), .frac(frac_x)
   );

   tgs_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
      .clock(clock), .en(en), .point(req_ff.point_y), .origin(origin_y_ff),
      .inv_spacing(inv_y_ff), .dim(ny), .res(res_y), .frac(frac_y)
   );

   tgs_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_z (
      .clock(clock), .en(en), .point(req_ff.point_z), .origin(origin_z_ff),
      .inv_spacing(inv_z_ff), .dim(nz), .res(res_z), .frac(frac_z)
   );

   // Linear addresses of the eight cell corners.
   always_comb begin
      base   = BW'(res_x.cell_idx) + BW'(nx) * BW'(res_y.cell_idx) +
               BW'(nxy_ff) * BW'(res_z.cell_idx);
      off[0] = '0;
      off[1] = BW'(1);
      off[2] = BW'(nx);
      off[3] = BW'(nx) + BW'(1);
      off[4] = BW'(nxy_ff);
      off[5] = BW'(nxy_ff) + BW'(1);
      off[6] = BW'(nx) + BW'(nxy_ff);
      off[7] = BW'(nx) + BW'(nxy_ff) + BW'(1);
      for (int g = 0; g < NCORNERS; g++) begin
         addr_in[g] = ADDR_W'(base + off[g]);
      end
   end

   // Grid writes happen at the same stage as the corner reads, which keeps them in order.
   assign mem_wr = en && vld_ff[5] && (ctl_ff[5].kind == KIND_WRITE) &&
                   (ctl_ff[5].status == ST_WRITE_DONE);

   for (genvar g = 0; g < NCORNERS; g++) begin : g_bank
      tgs_ram #(.WIDTH(32), .DEPTH(MEM_DEPTH)) u_ram (
         .clock(clock),
         .wr_en(mem_wr),
         .wr_addr(widx_ff[5]),
         .wr_data(wval_ff[5]),
         .rd_en(en),
         .rd_addr(addr_ff[g]),
         .rd_data(node[g])
      );
   end

   // Interpolate along x, then y, then z.
   tgs_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_x00 (
      .clock(clock), .en(en), .a(node[0]), .b(node[1]), .f(fx_ff[6]), .y(c00)
   );

   tgs_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_x10 (
      .clock(clock), .en(en), .a(node[2]), .b(node[3]), .f(fx_ff[6]), .y(c10)
   );

   tgs_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_x01 (
      .clock(clock), .en(en), .a(node[4]), .b(node[5]), .f(fx_ff[6]), .y(c01)
   );

   tgs_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_x11 (
      .clock(clock), .en(en), .a(node[6]), .b(node[7]), .f(fx_ff[6]), .y(c11)
   );

   tgs_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_y0 (
      .clock(clock), .en(en), .a(c00), .b(c10), .f(fy_ff[8]), .y(c0)
   );

   tgs_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_y1 (
      .clock(clock), .en(en), .a(c01), .b(c11), .f(fy_ff[8]), .y(c1)
   );

   tgs_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_z (
      .clock(clock), .en(en), .a(c0), .b(c1), .f(fz_ff[10]), .y(v)
   );

   // Output register; the value is zero for every status but a completed sample.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vld_ff[NSTAGE];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff.status       <= ctl_ff[NSTAGE].status;
         rsp_data_ff.sample_value <= (ctl_ff[NSTAGE].status == ST_SAMPLED) ? v : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A held response must stop new requests in the same cycle.
   a_stall_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request accepted while a response is held");

   // Only a completed sample carries a nonzero value.
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_SAMPLED) |-> (rsp_data.sample_value == '0))
      else $error("nonzero value on a response that is not a sample");

   // A write request always ends with a write status.
   a_write_status: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NSTAGE] && (ctl_ff[NSTAGE].kind == KIND_WRITE) |->
      (ctl_ff[NSTAGE].status == ST_WRITE_DONE) || (ctl_ff[NSTAGE].status == ST_WRITE_RANGE))
      else $error("write request with a sample status");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule
